>>> rtl/imh_pkg.sv
// imh_pkg: types and constants for the indexed max-heap.
// Holds the request/response transaction structs, action and error codes.
// No dependencies.
package imh_pkg;

    localparam int HANDLE_BITS    = 8;
    localparam int HANDLE_COUNT   = 256;
    localparam int KEY_PORT_BITS  = 16;
    localparam int COUNT_BITS     = 9;
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_KEY_BITS   = 16;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_DUPLICATE = 2'd2;
    localparam logic [1:0] ERR_ABSENT    = 2'd3;

    typedef struct packed {
        logic                     action;
        logic [HANDLE_BITS-1:0]   handle;
        logic [KEY_PORT_BITS-1:0] key;
    } heap_req_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]   top_handle;
        logic [KEY_PORT_BITS-1:0] top_key;
        logic [COUNT_BITS-1:0]    entry_count;
        logic                     is_empty;
        logic [1:0]               error_code;
    } heap_rsp_t;

endpackage

>>> rtl/indexed_max_heap.sv
// indexed_max_heap: binary max-heap of handles with a handle-to-slot table.
// Depends on imh_pkg (transaction structs, action and error codes).
// A rejected transaction reads the root and loads the response; a push sifts up from the
// new last slot; a delete reads the position, then the hole and last entry, and sifts up or down.
// Each level of the sift loop takes a read state and a compare state. One transaction at a
// time; the next is accepted in the cycle after the response loads, later if the previous
// response is still waiting.
// Reset: async active low; clears count, present marks, sequencer and response valid, not the memories.
module indexed_max_heap #(
    parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  imh_pkg::heap_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output imh_pkg::heap_rsp_t rsp
);

    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = POS_W + 1;   // child index range, one bit wider than a slot position
    localparam int HB    = imh_pkg::HANDLE_BITS;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEL_POS  = 4'd1;  // position read returns
    localparam logic [3:0] S_DEL_CMP  = 4'd2;  // hole and last entry return
    localparam logic [3:0] S_RISE_RD  = 4'd3;  // read parent
    localparam logic [3:0] S_RISE_CMP = 4'd4;  // compare with parent
    localparam logic [3:0] S_SINK_RD  = 4'd5;  // read children
    localparam logic [3:0] S_SINK_CMP = 4'd6;  // pick larger child
    localparam logic [3:0] S_ROOT     = 4'd7;  // read slot 0
    localparam logic [3:0] S_OUT      = 4'd8;  // load response register

    // ------------------------------------------------------------------
    // Storage: heap slots (two read ports), handle position table, marks
    // ------------------------------------------------------------------
    logic [HB-1:0]       slot_handle_mem [CAPACITY];
    logic [KEY_BITS-1:0] slot_key_mem    [CAPACITY];
    logic [POS_W-1:0]    position_mem    [imh_pkg::HANDLE_COUNT];

    logic [imh_pkg::HANDLE_COUNT-1:0] present_reg, present_next;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [HB-1:0]       cur_handle_reg, cur_handle_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [1:0]          err_reg, err_next;

    imh_pkg::heap_rsp_t  rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // memory ports
    logic [POS_W-1:0]    rd_a_addr, rd_b_addr;
    logic [HB-1:0]       rd_a_handle_reg, rd_b_handle_reg;
    logic [KEY_BITS-1:0] rd_a_key_reg, rd_b_key_reg;
    logic [POS_W-1:0]    pos_rd_reg;
    logic                wr_en;
    logic [POS_W-1:0]    wr_addr;
    logic [HB-1:0]       wr_handle;
    logic [KEY_BITS-1:0] wr_key;

    // datapath helpers
    logic [KEY_BITS-1:0] req_key;
    logic [POS_W-1:0]    parent;
    logic [POS_W-1:0]    last_pos;
    logic [POS_W-1:0]    pos_clamped;
    logic [IDX_W-1:0]    left_idx, right_idx, fill_ext;
    logic                left_ok, right_ok;
    logic [KEY_BITS-1:0] best_key_l;
    logic                take_left, take_right;

    assign req_key   = KEY_BITS'(32'(req.key));
    assign parent    = (pos_reg - POS_W'(1)) >> 1;
    assign last_pos  = POS_W'(fill_reg);
    assign fill_ext  = IDX_W'(fill_reg);
    assign left_idx  = {pos_reg, 1'b1};
    assign right_idx = left_idx + IDX_W'(1);
    assign left_ok   = left_idx < fill_ext;
    assign right_ok  = right_idx < fill_ext;

    // fill_reg has already been decremented here; a stale entry clamps to last
    assign pos_clamped = (CNT_W'(pos_rd_reg) > fill_reg) ? last_pos : pos_rd_reg;

    // sift-down choice: left on strict greater, right must beat the winner
    assign take_left  = rd_a_key_reg > cur_key_reg;
    assign best_key_l = take_left ? rd_a_key_reg : cur_key_reg;
    assign take_right = right_ok && (rd_b_key_reg > best_key_l);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_handle_mem[wr_addr] <= wr_handle;
            slot_key_mem[wr_addr]    <= wr_key;
            position_mem[wr_handle]  <= wr_addr;
        end
        rd_a_handle_reg <= slot_handle_mem[rd_a_addr];
        rd_a_key_reg    <= slot_key_mem[rd_a_addr];
        rd_b_handle_reg <= slot_handle_mem[rd_b_addr];
        rd_b_key_reg    <= slot_key_mem[rd_b_addr];
        pos_rd_reg      <= position_mem[req.handle];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        cur_handle_next = cur_handle_reg;
        cur_key_next    = cur_key_reg;
        err_next        = err_reg;
        present_next    = present_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_handle       = cur_handle_reg;
        wr_key          = cur_key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    err_next        = imh_pkg::ERR_OK;
                    cur_handle_next = req.handle;
                    cur_key_next    = req_key;
                    state_next      = S_ROOT;
                    if (req.action == imh_pkg::ACT_PUSH)
                    begin
                        if (fill_reg >= CNT_W'(CAPACITY))
                            err_next = imh_pkg::ERR_FULL;
                        else if (present_reg[req.handle])
                            err_next = imh_pkg::ERR_DUPLICATE;
                        else
                        begin
                            pos_next                 = POS_W'(fill_reg);
                            fill_next                = fill_reg + CNT_W'(1);
                            present_next[req.handle] = 1'b1;
                            state_next               = S_RISE_RD;
                        end
                    end
                    else
                    begin
                        if (!present_reg[req.handle] || fill_reg == '0)
                            err_next = imh_pkg::ERR_ABSENT;
                        else
                        begin
                            fill_next                = fill_reg - CNT_W'(1);
                            present_next[req.handle] = 1'b0;
                            state_next               = S_DEL_POS;
                        end
                    end
                end
            end

            S_DEL_POS:
            begin
                pos_next   = pos_clamped;
                rd_a_addr  = pos_clamped;
                rd_b_addr  = last_pos;
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP:
            begin
                // a = deleted entry, b = last entry, which is to fill the hole
                cur_handle_next = rd_b_handle_reg;
                cur_key_next    = rd_b_key_reg;
                if (pos_reg == last_pos)
                    state_next = S_ROOT;
                else if (rd_b_key_reg > rd_a_key_reg)
                    state_next = S_RISE_RD;
                else if (rd_a_key_reg > rd_b_key_reg)
                    state_next = S_SINK_RD;
                else
                begin
                    wr_en      = 1'b1;
                    wr_handle  = rd_b_handle_reg;
                    wr_key     = rd_b_key_reg;
                    state_next = S_ROOT;
                end
            end

            S_RISE_RD:
            begin
                rd_a_addr = parent;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_ROOT;
                end
                else
                    state_next = S_RISE_CMP;
            end

            S_RISE_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_key_reg < cur_key_reg)
                begin
                    // parent moves down into the current hole
                    wr_handle  = rd_a_handle_reg;
                    wr_key     = rd_a_key_reg;
                    pos_next   = parent;
                    state_next = S_RISE_RD;
                end
                else
                    state_next = S_ROOT;
            end

            S_SINK_RD:
            begin
                rd_a_addr = POS_W'(left_idx);
                rd_b_addr = right_ok ? POS_W'(right_idx) : POS_W'(left_idx);
                if (left_ok)
                    state_next = S_SINK_CMP;
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_ROOT;
                end
            end

            S_SINK_CMP:
            begin
                wr_en = 1'b1;
                if (take_right)
                begin
                    wr_handle  = rd_b_handle_reg;
                    wr_key     = rd_b_key_reg;
                    pos_next   = POS_W'(right_idx);
                    state_next = S_SINK_RD;
                end
                else if (take_left)
                begin
                    wr_handle  = rd_a_handle_reg;
                    wr_key     = rd_a_key_reg;
                    pos_next   = POS_W'(left_idx);
                    state_next = S_SINK_RD;
                end
                else
                    state_next = S_ROOT;
            end

            S_ROOT:
            begin
                rd_a_addr  = '0;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                rd_a_addr = '0;
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.top_handle  = (fill_reg != '0) ? rd_a_handle_reg : '0;
                    rsp_next.top_key     = (fill_reg != '0) ?
                        imh_pkg::KEY_PORT_BITS'(32'(rd_a_key_reg)) : '0;
                    rsp_next.entry_count = imh_pkg::COUNT_BITS'(fill_reg);
                    rsp_next.is_empty    = (fill_reg == '0);
                    rsp_next.error_code  = err_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            present_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            present_reg   <= present_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_handle_reg <= cur_handle_next;
        cur_key_reg    <= cur_key_next;
        err_reg        <= err_next;
        rsp_reg        <= rsp_next;
    end

endmodule
